// ===== src/smd_pkg.sv =====
// Shared constants, types and the glyph table of the seven-segment display driver.
package smd_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int PWM_STEPS    = 10;
  localparam int DIGITS       = 4;
  localparam int GLYPH_COUNT  = 27;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CALC_W       = 10;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [3:0] BRIGHT_RESET = 4'd10;
  localparam logic [7:0] DASH_CODE    = 8'd16;
  localparam logic [7:0] BLANK_CODE   = 8'hFF;
  localparam logic [7:0] DP_MASK      = 8'h80;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] VIEW_EDIT     = 2'd0;
  localparam logic [1:0] VIEW_COMPLETE = 2'd1;

  localparam logic [2:0] LED_FIXED_0 = 3'd0;
  localparam logic [2:0] LED_FIXED_1 = 3'd1;
  localparam logic [2:0] LED_FIXED_2 = 3'd2;
  localparam logic [2:0] LED_FIXED_3 = 3'd3;
  localparam logic [2:0] LED_PAIR_12 = 3'd4;
  localparam logic [2:0] LED_PAIR_23 = 3'd5;
  localparam logic [2:0] LED_PAIR_13 = 3'd6;

  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h70, 8'h76, 8'h7C, 8'h39, 8'h50, 8'h1E, 8'h40, 8'h5C, 8'h5E, 8'h06,
    8'h54, 8'h71, 8'h73, 8'h77, 8'h78, 8'h20, 8'h79
  };

  typedef struct packed {
    logic [7:0] code;
    logic       dp;
    logic [1:0] digit;
    logic [1:0] led;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_slot_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [7:0] glyph(input logic [7:0] code, input logic dp);
    logic [7:0] seg;
    seg = 8'h00;
    if (code < 8'(GLYPH_COUNT)) begin
      seg = GLYPH_ROM[code[4:0]] | (dp ? DP_MASK : 8'h00);
    end
    return seg;
  endfunction

endpackage

// ===== src/smd_req_if.sv =====
// Request channel carrying buffer writes and refresh ticks.
interface smd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] write_addr;
  logic [7:0] write_code;
  logic [6:0] text_length;
  logic [7:0] cursor_code;
  logic [1:0] view_mode;
  logic       hide_digits;
  logic [3:0] scroll_row;
  logic [2:0] led_pattern;

  modport source (
    output valid, req_type, write_addr, write_code, text_length, cursor_code,
           view_mode, hide_digits, scroll_row, led_pattern,
    input  ready
  );
  modport sink (
    input  valid, req_type, write_addr, write_code, text_length, cursor_code,
           view_mode, hide_digits, scroll_row, led_pattern,
    output ready
  );
endinterface

// ===== src/smd_frame_if.sv =====
// Frame channel carrying segment, digit and LED select values.
interface smd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [1:0] digit_select;
  logic [1:0] led_select;

  modport source (output valid, segments, digit_select, led_select, input ready);
  modport sink (input valid, segments, digit_select, led_select, output ready);
endinterface

// ===== src/seven_segment_mux_display.sv =====
// Top level of the multiplexed seven-segment display driver with PWM dimming.
//
// Items arrive on req_i: a write item stores one glyph code in the character
// buffer, a tick item steps the PWM counter and, when the digit blanks or the
// next digit is lit, yields one frame on frm_o. The brightness register is
// written through cfg_we_i and cfg_wdata_i; the user must write it only while
// the block is idle, as the block itself does not enforce this. One item is
// accepted per cycle while req_i.ready is high. For a tick, the buffer is read
// at the edge that accepts it, the frame then enters the queue, and the glyph
// is rendered as the frame is loaded into the output register.
// A four-entry queue decouples the front end from the output register; when
// the receiver stalls, frames collect there and req_i.ready drops once the
// queue together with the frame in flight would fill it.
// Reset clears the PWM counter, digit index, blanking flag and LED phase and
// sets brightness to 10. The character buffer is not cleared: every position
// must be written before it is displayed.
module seven_segment_mux_display (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  smd_req_if.sink    req_i,
  smd_frame_if.source frm_o
);

  smd_pkg::frame_slot_t   push;
  smd_pkg::frame_slot_t   head;
  smd_pkg::queue_status_t qstat;
  logic                   pop;

  smd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .qstat_i     (qstat),
    .push_o      (push)
  );

  smd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  smd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .frm_o  (frm_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= smd_pkg::QCNT_W'(smd_pkg::QDEPTH))
    else $error("Frame queue holds more items than its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (qstat.count < smd_pkg::QCNT_W'(smd_pkg::QDEPTH)))
    else $error("Frame pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type == smd_pkg::REQ_WRITE) |=> !push.valid)
    else $error("A buffer write produced a frame.");
`endif

endmodule

// ===== src/smd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/smd_front.sv =====
// Front end: accepts items, steps the PWM counter, writes and reads the character buffer.
module smd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  smd_req_if.sink              req_i,
  input  smd_pkg::queue_status_t qstat_i,
  output smd_pkg::frame_slot_t push_o
);

  logic [3:0] brightness_q;
  logic [3:0] pwm_q, pwm_d;
  logic [1:0] digit_q, digit_d;
  logic       blank_q, blank_d;
  logic [1:0] led_q, led_d;

  logic       s1_valid_q;
  logic       s1_use_buf_q;
  logic [7:0] s1_code_q;
  logic       s1_dp_q;
  logic [1:0] s1_digit_q;
  logic [1:0] s1_led_q;

  logic [smd_pkg::QCNT_W:0] occupancy;
  logic accept, is_tick, is_write, event_hit, hit_bright, hit_end;
  logic addr_ok, use_buf, dp;
  logic [7:0] code;
  logic [smd_pkg::CALC_W-1:0] len_sat, len_ext, col_ext, sel, idx, waddr_ext;
  logic [7:0] rdata;

  assign occupancy = {1'b0, qstat_i.count} + {{smd_pkg::QCNT_W{1'b0}}, s1_valid_q};
  assign req_i.ready = occupancy < (smd_pkg::QCNT_W + 1)'(smd_pkg::QDEPTH);
  assign accept   = req_i.valid && req_i.ready;
  assign is_write = accept && (req_i.req_type == smd_pkg::REQ_WRITE);
  assign is_tick  = accept && (req_i.req_type == smd_pkg::REQ_TICK);

  assign waddr_ext = smd_pkg::CALC_W'(req_i.write_addr);
  assign addr_ok   = waddr_ext < smd_pkg::CALC_W'(smd_pkg::BUFFER_DEPTH);

  always_comb begin
    hit_bright = (pwm_q == brightness_q);
    hit_end    = (pwm_q == 4'(smd_pkg::PWM_STEPS));
    event_hit  = hit_bright || hit_end;
    blank_d    = blank_q;
    if (hit_bright) begin
      blank_d = 1'b1;
    end
    if (hit_end) begin
      blank_d = 1'b0;
      digit_d = digit_q + 2'd1;
      pwm_d   = 4'd0;
    end else begin
      digit_d = digit_q;
      pwm_d   = pwm_q + 4'd1;
    end
  end

  always_comb begin
    len_ext = smd_pkg::CALC_W'(req_i.text_length);
    len_sat = (len_ext > smd_pkg::CALC_W'(smd_pkg::BUFFER_DEPTH)) ?
              smd_pkg::CALC_W'(smd_pkg::BUFFER_DEPTH) : len_ext;
    col_ext = smd_pkg::CALC_W'(digit_d);
    use_buf = 1'b0;
    code    = smd_pkg::BLANK_CODE;
    dp      = 1'b0;
    sel     = '0;
    idx     = col_ext;
    if (!blank_d && req_i.view_mode == smd_pkg::VIEW_EDIT) begin
      if (len_sat >= smd_pkg::CALC_W'(smd_pkg::DIGITS - 1)) begin
        sel = smd_pkg::CALC_W'(smd_pkg::DIGITS - 1);
        idx = len_sat - smd_pkg::CALC_W'(smd_pkg::DIGITS - 1) + col_ext;
      end else begin
        sel = len_sat;
        idx = col_ext;
      end
      if (col_ext == sel) begin
        code = req_i.cursor_code;
        dp   = 1'b1;
      end else if (idx < len_sat) begin
        if (req_i.hide_digits) begin
          code = smd_pkg::DASH_CODE;
        end else begin
          use_buf = 1'b1;
        end
      end
    end else if (!blank_d && req_i.view_mode == smd_pkg::VIEW_COMPLETE) begin
      idx = col_ext + (smd_pkg::CALC_W'(req_i.scroll_row) << 2);
      if (idx < len_sat) begin
        use_buf = 1'b1;
      end
    end
  end

  always_comb begin
    case (req_i.led_pattern)
      smd_pkg::LED_FIXED_0, smd_pkg::LED_FIXED_1,
      smd_pkg::LED_FIXED_2, smd_pkg::LED_FIXED_3: begin
        led_d = req_i.led_pattern[1:0];
      end
      smd_pkg::LED_PAIR_12: begin
        led_d = {1'b0, digit_d[0]} + 2'd1;
      end
      smd_pkg::LED_PAIR_23: begin
        led_d = {1'b0, digit_d[0]} + 2'd2;
      end
      smd_pkg::LED_PAIR_13: begin
        led_d = (led_q == 2'd1) ? 2'd3 : 2'd1;
      end
      default: begin
        led_d = (led_q == 2'd3) ? 2'd1 : led_q + 2'd1;
      end
    endcase
  end

  smd_ram #(
    .WIDTH (8),
    .DEPTH (smd_pkg::BUFFER_DEPTH)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (is_write && addr_ok),
    .waddr_i (waddr_ext[smd_pkg::IDX_W-1:0]),
    .wdata_i (req_i.write_code),
    .re_i    (is_tick && event_hit && use_buf),
    .raddr_i (idx[smd_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= smd_pkg::BRIGHT_RESET;
      pwm_q        <= '0;
      digit_q      <= '0;
      blank_q      <= 1'b0;
      led_q        <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        brightness_q <= cfg_wdata_i;
      end
      s1_valid_q <= is_tick && event_hit;
      if (is_tick) begin
        pwm_q   <= pwm_d;
        digit_q <= digit_d;
        blank_q <= blank_d;
        if (event_hit) begin
          led_q <= led_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick && event_hit) begin
      s1_use_buf_q <= use_buf;
      s1_code_q    <= code;
      s1_dp_q      <= dp;
      s1_digit_q   <= digit_d;
      s1_led_q     <= led_d;
    end
  end

  assign push_o.valid       = s1_valid_q;
  assign push_o.frame.code  = s1_use_buf_q ? rdata : s1_code_q;
  assign push_o.frame.dp    = s1_dp_q;
  assign push_o.frame.digit = s1_digit_q;
  assign push_o.frame.led   = s1_led_q;

endmodule

// ===== src/smd_queue.sv =====
// Short frame queue between the front end and the output stage.
module smd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smd_pkg::frame_slot_t   push_i,
  input  logic                   pop_i,
  output smd_pkg::frame_slot_t   head_o,
  output smd_pkg::queue_status_t qstat_o
);

  smd_pkg::frame_t                mem_q [smd_pkg::QDEPTH];
  logic [smd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [smd_pkg::QCNT_W-1:0]     count_q;
  logic                           do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

  assign head_o.valid   = count_q != '0;
  assign head_o.frame   = mem_q[rd_ptr_q];
  assign qstat_o.count  = count_q;

endmodule

// ===== src/smd_back.sv =====
// Output stage: renders the glyph and holds the frame until the receiver takes it.
module smd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smd_pkg::frame_slot_t head_i,
  output logic                 pop_o,
  smd_frame_if.source          frm_o
);

  logic       out_valid_q;
  logic [7:0] seg_q;
  logic [1:0] digit_q;
  logic [1:0] led_q;
  logic       load;

  assign load  = head_i.valid && (!out_valid_q || frm_o.ready);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (frm_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_q   <= smd_pkg::glyph(head_i.frame.code, head_i.frame.dp);
      digit_q <= head_i.frame.digit;
      led_q   <= head_i.frame.led;
    end
  end

  assign frm_o.valid        = out_valid_q;
  assign frm_o.segments     = seg_q;
  assign frm_o.digit_select = digit_q;
  assign frm_o.led_select   = led_q;

endmodule

// ===== tb/sv/tb_seven_segment_mux_display.sv =====
// Self-checking testbench for the multiplexed seven-segment display driver.
module tb_seven_segment_mux_display;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] VIEW_BLANK = 2'd2;
  localparam logic [1:0] VIEW_SPARE = 2'd3;
  localparam logic [2:0] LED_ROTATE = 3'd7;

  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [7:0] SEG_FONT [smd_pkg::GLYPH_COUNT] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h70, 8'h76, 8'h7C, 8'h39, 8'h50, 8'h1E, 8'h40, 8'h5C, 8'h5E, 8'h06,
    8'h54, 8'h71, 8'h73, 8'h77, 8'h78, 8'h20, 8'h79
  };

  typedef struct {
    logic       kind;
    logic [5:0] addr;
    logic [7:0] code;
    logic [6:0] length;
    logic [7:0] cursor;
    logic [1:0] view;
    logic       hide;
    logic [3:0] row;
    logic [2:0] pattern;
  } panel_req_t;

  typedef struct {
    logic [7:0] seg;
    logic [1:0] digit;
    logic [1:0] led;
  } panel_frame_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  smd_req_if   req_ch ();
  smd_frame_if frm_ch ();

  seven_segment_mux_display u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch.sink),
    .frm_o       (frm_ch.source)
  );

  logic [3:0]   bright_q;
  logic [3:0]   pwm_q;
  logic [1:0]   digit_q;
  logic         dark_q;
  logic [1:0]   led_q;
  logic [7:0]   glyph_store [smd_pkg::BUFFER_DEPTH];
  panel_frame_t frames_due [$];

  int errors;
  int items_sent;
  int writes_sent;
  int frames_seen;
  int levels_used;
  int quiet;
  int hold_len;
  bit send_calm;
  bit recv_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] font_of(input logic [7:0] code, input logic point);
    if (code >= smd_pkg::GLYPH_COUNT) return 8'h00;
    return SEG_FONT[code] | (point ? smd_pkg::DP_MASK : 8'h00);
  endfunction

  function automatic void step_display(input panel_req_t it);
    bit           fire;
    int           len;
    int           col;
    int           sel;
    int           idx;
    logic [7:0]   seg;
    panel_frame_t shown;
    if (it.kind == smd_pkg::REQ_WRITE) begin
      if (int'(it.addr) < smd_pkg::BUFFER_DEPTH) glyph_store[it.addr] = it.code;
      return;
    end
    fire = 1'b0;
    if (pwm_q == bright_q) begin
      dark_q = 1'b1;
      fire   = 1'b1;
    end
    if (pwm_q == 4'(smd_pkg::PWM_STEPS)) begin
      digit_q = digit_q + 2'd1;
      dark_q  = 1'b0;
      fire    = 1'b1;
      pwm_q   = 4'd0;
    end else begin
      pwm_q = pwm_q + 4'd1;
    end
    if (!fire) return;
    len = (int'(it.length) > smd_pkg::BUFFER_DEPTH) ? smd_pkg::BUFFER_DEPTH : int'(it.length);
    col = int'(digit_q);
    seg = 8'h00;
    if (!dark_q && it.view == smd_pkg::VIEW_EDIT) begin
      if (len >= smd_pkg::DIGITS - 1) begin
        sel = smd_pkg::DIGITS - 1;
        idx = len - (smd_pkg::DIGITS - 1) + col;
      end else begin
        sel = len;
        idx = col;
      end
      if (col == sel) begin
        seg = font_of(it.cursor, 1'b1);
      end else if (idx < len) begin
        seg = it.hide ? font_of(smd_pkg::DASH_CODE, 1'b0) : font_of(glyph_store[idx], 1'b0);
      end
    end else if (!dark_q && it.view == smd_pkg::VIEW_COMPLETE) begin
      idx = col + int'(it.row) * smd_pkg::DIGITS;
      if (idx < len) seg = font_of(glyph_store[idx], 1'b0);
    end
    case (it.pattern)
      smd_pkg::LED_PAIR_12: led_q = 2'(col % 2 + 1);
      smd_pkg::LED_PAIR_23: led_q = 2'(col % 2 + 2);
      smd_pkg::LED_PAIR_13: led_q = (led_q == 2'd1) ? 2'd3 : 2'd1;
      LED_ROTATE:           led_q = (led_q == 2'd3) ? 2'd1 : led_q + 2'd1;
      default:              led_q = it.pattern[1:0];
    endcase
    shown.seg   = seg;
    shown.digit = digit_q;
    shown.led   = led_q;
    frames_due.push_back(shown);
  endfunction

  always @(posedge clk) begin : req_monitor
    panel_req_t seen;
    if (rst_n && req_ch.valid && req_ch.ready) begin
      seen.kind    = req_ch.req_type;
      seen.addr    = req_ch.write_addr;
      seen.code    = req_ch.write_code;
      seen.length  = req_ch.text_length;
      seen.cursor  = req_ch.cursor_code;
      seen.view    = req_ch.view_mode;
      seen.hide    = req_ch.hide_digits;
      seen.row     = req_ch.scroll_row;
      seen.pattern = req_ch.led_pattern;
      step_display(seen);
    end
  end

  always @(posedge clk) begin : frame_checker
    panel_frame_t want;
    if (rst_n && frm_ch.valid && frm_ch.ready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: segments %02h digit_select %0d led_select %0d",
               frm_ch.segments, frm_ch.digit_select, frm_ch.led_select);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (frm_ch.segments !== want.seg) begin
          $error("segments mismatch: expected %02h, actual %02h", want.seg, frm_ch.segments);
          errors++;
        end
        if (frm_ch.digit_select !== want.digit) begin
          $error("digit_select mismatch: expected %0d, actual %0d",
                 want.digit, frm_ch.digit_select);
          errors++;
        end
        if (frm_ch.led_select !== want.led) begin
          $error("led_select mismatch: expected %0d, actual %0d", want.led, frm_ch.led_select);
          errors++;
        end
      end
    end
  end

  initial begin : frame_sink
    int stall;
    frm_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_len > 0) begin
        frm_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = recv_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        frm_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frm_ch.ready <= 1'b1;
      do @(posedge clk); while (!frm_ch.valid && hold_len == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (frm_ch.valid && frm_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic panel_req_t make_tick(input int length, input logic [7:0] cursor,
                                           input logic [1:0] view, input logic hide,
                                           input logic [3:0] row, input logic [2:0] pattern);
    panel_req_t it;
    it.kind    = smd_pkg::REQ_TICK;
    it.addr    = 6'($urandom);
    it.code    = 8'($urandom);
    it.length  = 7'(length);
    it.cursor  = cursor;
    it.view    = view;
    it.hide    = hide;
    it.row     = row;
    it.pattern = pattern;
    return it;
  endfunction

  function automatic panel_req_t random_view();
    int         len;
    logic [7:0] cursor;
    logic [1:0] view;
    case ($urandom_range(0, 3))
      0:       len = $urandom_range(0, 3);
      1:       len = $urandom_range(4, 63);
      2:       len = smd_pkg::BUFFER_DEPTH;
      default: len = $urandom_range(65, 127);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      cursor = 8'($urandom);
    end else begin
      cursor = 8'($urandom_range(0, smd_pkg::GLYPH_COUNT - 1));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: view = smd_pkg::VIEW_EDIT;
      4, 5, 6, 7: view = smd_pkg::VIEW_COMPLETE;
      8:          view = VIEW_BLANK;
      default:    view = VIEW_SPARE;
    endcase
    return make_tick(len, cursor, view, 1'($urandom), 4'($urandom), 3'($urandom));
  endfunction

  task automatic send_item(input panel_req_t it);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.kind;
    req_ch.write_addr  <= it.addr;
    req_ch.write_code  <= it.code;
    req_ch.text_length <= it.length;
    req_ch.cursor_code <= it.cursor;
    req_ch.view_mode   <= it.view;
    req_ch.hide_digits <= it.hide;
    req_ch.scroll_row  <= it.row;
    req_ch.led_pattern <= it.pattern;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (it.kind == smd_pkg::REQ_WRITE) writes_sent++;
  endtask

  task automatic send_period(input panel_req_t it);
    repeat (smd_pkg::PWM_STEPS + 1) send_item(it);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [3:0] level);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we   <= 1'b0;
    bright_q  = level;
    levels_used++;
  endtask

  task automatic test_buffer_fill();
    panel_req_t it;
    int         a;
    for (a = 0; a < smd_pkg::BUFFER_DEPTH; a++) begin
      it      = make_tick(0, 8'd0, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_FIXED_0);
      it.kind = smd_pkg::REQ_WRITE;
      it.addr = 6'(a);
      it.code = (a == smd_pkg::BUFFER_DEPTH - 1) ? 8'hFF : 8'(a % 32);
      send_item(it);
    end
  endtask

  task automatic test_reset_brightness();
    send_period(make_tick(5, 8'd7, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, LED_ROTATE));
    send_period(make_tick(5, 8'd7, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, LED_ROTATE));
  endtask

  task automatic test_view_cases();
    set_brightness(4'd0);
    send_period(make_tick(0, 8'd0, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_FIXED_0));
    send_period(make_tick(2, 8'd26, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_FIXED_1));
    send_period(make_tick(127, 8'hFF, smd_pkg::VIEW_EDIT, 1'b1, 4'd0, smd_pkg::LED_FIXED_2));
    send_period(make_tick(64, 8'd27, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_FIXED_3));
    send_period(make_tick(3, 8'd9, smd_pkg::VIEW_COMPLETE, 1'b0, 4'd0, smd_pkg::LED_PAIR_12));
    send_period(make_tick(64, 8'd1, smd_pkg::VIEW_COMPLETE, 1'b0, 4'd15, smd_pkg::LED_PAIR_23));
    send_period(make_tick(40, 8'd3, VIEW_BLANK, 1'b0, 4'd1, smd_pkg::LED_PAIR_13));
    send_period(make_tick(64, 8'd5, VIEW_SPARE, 1'b1, 4'd2, LED_ROTATE));
  endtask

  task automatic test_brightness_levels();
    panel_req_t it;
    set_brightness(4'd15);
    send_period(make_tick(10, 8'd12, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_PAIR_13));
    set_brightness(4'd5);
    send_period(make_tick(20, 8'd2, smd_pkg::VIEW_COMPLETE, 1'b0, 4'd3, smd_pkg::LED_PAIR_12));
    it      = make_tick(0, 8'd0, smd_pkg::VIEW_EDIT, 1'b0, 4'd0, smd_pkg::LED_FIXED_0);
    it.kind = smd_pkg::REQ_WRITE;
    it.addr = 6'd12;
    it.code = 8'd8;
    send_item(it);
    send_period(make_tick(20, 8'd2, smd_pkg::VIEW_COMPLETE, 1'b0, 4'd3, smd_pkg::LED_PAIR_12));
  endtask

  task automatic test_backpressure();
    set_brightness(4'd0);
    send_calm = 1'b1;
    hold_len  = HOLD_CYCLES;
    repeat (6) send_period(make_tick(64, 8'd4, smd_pkg::VIEW_COMPLETE, 1'b0, 4'd0, LED_ROTATE));
    send_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    panel_req_t view;
    panel_req_t it;
    int         phase;
    int         n;
    logic [3:0] level;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       level = 4'd0;
        1:       level = 4'd15;
        2:       level = smd_pkg::BRIGHT_RESET;
        3:       level = 4'd1;
        default: level = 4'($urandom_range(0, 15));
      endcase
      set_brightness(level);
      view = random_view();
      for (n = 0; n < 220; n++) begin
        if (n % 60 == 0) begin
          send_calm = ($urandom_range(0, 3) == 0);
          recv_calm = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 15) == 0) view = random_view();
        it      = view;
        it.addr = 6'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          it.kind = smd_pkg::REQ_WRITE;
          if ($urandom_range(0, 4) == 0) begin
            it.code = 8'($urandom);
          end else begin
            it.code = 8'($urandom_range(0, smd_pkg::GLYPH_COUNT - 1));
          end
        end else begin
          it.code = 8'($urandom);
        end
        send_item(it);
      end
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 4'd0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= smd_pkg::REQ_TICK;
    req_ch.write_addr  <= 6'd0;
    req_ch.write_code  <= 8'd0;
    req_ch.text_length <= 7'd0;
    req_ch.cursor_code <= 8'd0;
    req_ch.view_mode   <= smd_pkg::VIEW_EDIT;
    req_ch.hide_digits <= 1'b0;
    req_ch.scroll_row  <= 4'd0;
    req_ch.led_pattern <= smd_pkg::LED_FIXED_0;
    bright_q    = smd_pkg::BRIGHT_RESET;
    pwm_q       = 4'd0;
    digit_q     = 2'd0;
    dark_q      = 1'b0;
    led_q       = 2'd0;
    errors      = 0;
    items_sent  = 0;
    writes_sent = 0;
    frames_seen = 0;
    levels_used = 0;
    quiet       = 0;
    hold_len    = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_buffer_fill();
    test_reset_brightness();
    test_view_cases();
    test_brightness_levels();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    $display("Sent %0d items (%0d buffer writes) and checked %0d frames over %0d brightness",
             items_sent, writes_sent, frames_seen, levels_used);
    $display("settings, covering every view mode, LED pattern and a long receiver hold.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/smd_pkg.sv
src/smd_req_if.sv
src/smd_frame_if.sv
src/smd_ram.sv
src/smd_front.sv
src/smd_queue.sv
src/smd_back.sv
src/seven_segment_mux_display.sv
tb/sv/tb_seven_segment_mux_display.sv
